### hw/rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; every other RTL file refers to this package by scoped names.
package hsv2rgb_pkg;

    // Degrees per hue sector and full-scale channel level
    localparam int unsigned HUE_SECTOR_DEG = 60;
    localparam int unsigned FULL_LEVEL     = 255;
    localparam int unsigned NUM_THRESH     = 8;    // sector boundaries below 512
    localparam logic [13:0] FRAC_DEN       = 14'd15300;   // 60 * 255

    // Reciprocal multipliers for exact floor division by a constant.
    // floor(x / 15300) = floor(floor(x / 4) / 3825), the latter as (y * RECIP_3825) >> 32
    localparam logic [20:0] RECIP_3825 = 21'd1122868;
    localparam int unsigned SHIFT_3825 = 32;
    // floor(x / 255) for x < 65536 as (x * RECIP_255) >> 24
    localparam logic [16:0] RECIP_255  = 17'd65794;
    localparam int unsigned SHIFT_255  = 24;

    // Hue sector codes; codes above SECTOR_MR map like SECTOR_MR
    localparam logic [3:0] SECTOR_RY = 4'd0;
    localparam logic [3:0] SECTOR_YG = 4'd1;
    localparam logic [3:0] SECTOR_GC = 4'd2;
    localparam logic [3:0] SECTOR_CB = 4'd3;
    localparam logic [3:0] SECTOR_BM = 4'd4;
    localparam logic [3:0] SECTOR_MR = 4'd5;

    // Input word
    typedef struct packed {
        logic [8:0] hue_deg;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // Result word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Sector stage to level pipeline
    typedef struct packed {
        logic       valid;
        logic [3:0] sector;
        logic [5:0] rem;
        logic [7:0] sat;
        logic [7:0] val;
    } sect_t;

    // Level pipeline to output select
    typedef struct packed {
        logic       valid;
        logic [3:0] sector;
        logic [7:0] val;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } level_t;

endpackage

### hw/rtl/hsv2rgb_sector.sv
// Stage 1: splits the hue into sector and remainder within the sector.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hsv2rgb_pkg::hsv_t  hsv,
    output hsv2rgb_pkg::sect_t sect
);

    logic       valid_reg;
    logic [3:0] sector_reg, sector_next;
    logic [5:0] rem_reg, rem_next;
    logic [7:0] sat_reg;
    logic [7:0] val_reg;
    logic [8:0] base;

    // Independent compares against each sector boundary; the highest one passed wins
    always_comb
    begin
        sector_next = hsv2rgb_pkg::SECTOR_RY;
        base        = '0;
        for (int i = 1; i <= int'(hsv2rgb_pkg::NUM_THRESH); i++)
        begin
            if (hsv.hue_deg >= 9'(i * int'(hsv2rgb_pkg::HUE_SECTOR_DEG)))
            begin
                sector_next = 4'(i);
                base        = 9'(i * int'(hsv2rgb_pkg::HUE_SECTOR_DEG));
            end
        end
        rem_next = 6'(hsv.hue_deg - base);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        rem_reg    <= rem_next;
        sat_reg    <= hsv.saturation;
        val_reg    <= hsv.brightness;
    end

    assign sect.valid  = valid_reg;
    assign sect.sector = sector_reg;
    assign sect.rem    = rem_reg;
    assign sect.sat    = sat_reg;
    assign sect.val    = val_reg;

endmodule

### hw/rtl/hsv2rgb_level.sv
// Stages 2 to 4: forms the p, q and t levels with exact truncating division.
// Depends on hsv2rgb_pkg.
module hsv2rgb_level (
    input  logic                clk,
    input  logic                rst_n,
    input  hsv2rgb_pkg::sect_t  sect,
    output hsv2rgb_pkg::level_t level
);

    logic [2:0] valid_reg;

    // Stage 2 registers: numerators
    logic [3:0]  sec2_reg;
    logic [7:0]  val2_reg;
    logic [7:0]  nump_reg;
    logic [13:0] numq_reg;
    logic [13:0] numt_reg;
    // Stage 3 registers: products with v
    logic [3:0]  sec3_reg;
    logic [7:0]  val3_reg;
    logic [15:0] prodp_reg;
    logic [21:0] prodq_reg;
    logic [21:0] prodt_reg;
    // Stage 4 registers: quotients
    logic [3:0]  sec4_reg;
    logic [7:0]  val4_reg;
    logic [7:0]  p_reg, q_reg, t_reg;

    logic [6:0]  comp;
    logic [13:0] sq, st;
    logic [32:0] divp;
    logic [40:0] divq, divt;

    // Stage 2 math: s*rem and s*(60-rem) against 15300
    always_comb
    begin
        comp = 7'(hsv2rgb_pkg::HUE_SECTOR_DEG) - {1'b0, sect.rem};
        sq   = {6'b0, sect.sat} * {8'b0, sect.rem};
        st   = {6'b0, sect.sat} * {7'b0, comp};
    end

    // Stage 4 math: reciprocal multiplies
    always_comb
    begin
        divp = 33'(prodp_reg) * 33'(hsv2rgb_pkg::RECIP_255);
        divq = 41'(prodq_reg[21:2]) * 41'(hsv2rgb_pkg::RECIP_3825);
        divt = 41'(prodt_reg[21:2]) * 41'(hsv2rgb_pkg::RECIP_3825);
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], sect.valid};
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        sec2_reg  <= sect.sector;
        val2_reg  <= sect.val;
        nump_reg  <= 8'(hsv2rgb_pkg::FULL_LEVEL) - sect.sat;
        numq_reg  <= hsv2rgb_pkg::FRAC_DEN - sq;
        numt_reg  <= hsv2rgb_pkg::FRAC_DEN - st;

        sec3_reg  <= sec2_reg;
        val3_reg  <= val2_reg;
        prodp_reg <= {8'b0, val2_reg} * {8'b0, nump_reg};
        prodq_reg <= {14'b0, val2_reg} * {8'b0, numq_reg};
        prodt_reg <= {14'b0, val2_reg} * {8'b0, numt_reg};

        sec4_reg  <= sec3_reg;
        val4_reg  <= val3_reg;
        p_reg     <= divp[hsv2rgb_pkg::SHIFT_255 +: 8];
        q_reg     <= divq[hsv2rgb_pkg::SHIFT_3825 +: 8];
        t_reg     <= divt[hsv2rgb_pkg::SHIFT_3825 +: 8];
    end

    assign level.valid  = valid_reg[2];
    assign level.sector = sec4_reg;
    assign level.val    = val4_reg;
    assign level.p      = p_reg;
    assign level.q      = q_reg;
    assign level.t      = t_reg;

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, fully pipelined: one word accepted every cycle, busy stays low.
// From start to done each word passes the registered stages sector split, numerators, products with v,
// reciprocal division and channel select. done is high for one cycle per word.
// Reset clears the valid bits only; data registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_sector and hsv2rgb_level.
module hsv_to_rgb_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hsv2rgb_pkg::hsv_t  hsv,
    output logic               done,
    output hsv2rgb_pkg::rgb_t  rgb
);

    hsv2rgb_pkg::sect_t  sect;
    hsv2rgb_pkg::level_t level;
    hsv2rgb_pkg::rgb_t   rgb_reg, rgb_next;
    logic                done_reg;

    hsv2rgb_sector u_sector (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hsv   (hsv),
        .sect  (sect)
    );

    hsv2rgb_level u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .sect  (sect),
        .level (level)
    );

    // Sector selects which level drives each channel
    always_comb
    begin
        unique case (level.sector)
            hsv2rgb_pkg::SECTOR_RY: rgb_next = '{level.val, level.t, level.p};
            hsv2rgb_pkg::SECTOR_YG: rgb_next = '{level.q, level.val, level.p};
            hsv2rgb_pkg::SECTOR_GC: rgb_next = '{level.p, level.val, level.t};
            hsv2rgb_pkg::SECTOR_CB: rgb_next = '{level.p, level.q, level.val};
            hsv2rgb_pkg::SECTOR_BM: rgb_next = '{level.t, level.p, level.val};
            default:                rgb_next = '{level.val, level.p, level.q};
        endcase
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= level.valid;
    end

    // Result word
    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rgb  = rgb_reg;

endmodule

### verif/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for hsv_to_rgb_converter: directed sector/extreme words, then
// random streams with and without sender idling, each result checked against a local predictor.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter RTL.
module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF     = 2;
    localparam int          DRAIN_CYCLES = 20;       // exceeds the block's start-to-done latency, leave margin
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;

    // Pending word: the input that was accepted and the colour it must produce
    typedef struct {
        hsv2rgb_pkg::hsv_t px;
        hsv2rgb_pkg::rgb_t want;
    } pending_px_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    hsv2rgb_pkg::hsv_t hsv;
    logic              done;
    hsv2rgb_pkg::rgb_t rgb;

    pending_px_t pending_px[$];
    int          mismatch_count;
    int unsigned cycle_count;

    hsv_to_rgb_converter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .hsv   (hsv),
        .done  (done),
        .rgb   (rgb)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Watchdog
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Colour predictor: sector split plus exact floor-divided p/q/t levels
    function automatic hsv2rgb_pkg::rgb_t predict_rgb(input hsv2rgb_pkg::hsv_t px);
        int unsigned       v;
        int unsigned       s;
        int unsigned       rem;
        int unsigned       frac_den;
        int unsigned       p;
        int unsigned       q;
        int unsigned       t;
        logic [3:0]        sector;
        hsv2rgb_pkg::rgb_t c;
        v        = px.brightness;
        s        = px.saturation;
        frac_den = hsv2rgb_pkg::HUE_SECTOR_DEG * hsv2rgb_pkg::FULL_LEVEL;
        if (s == 0)
        begin
            c.red   = v[7:0];
            c.green = v[7:0];
            c.blue  = v[7:0];
            return c;
        end
        sector = 4'(px.hue_deg / hsv2rgb_pkg::HUE_SECTOR_DEG);
        rem    = px.hue_deg % hsv2rgb_pkg::HUE_SECTOR_DEG;
        p      = (v * (hsv2rgb_pkg::FULL_LEVEL - s)) / hsv2rgb_pkg::FULL_LEVEL;
        q      = (v * (frac_den - s * rem)) / frac_den;
        t      = (v * (frac_den - s * (hsv2rgb_pkg::HUE_SECTOR_DEG - rem))) / frac_den;
        case (sector)
            hsv2rgb_pkg::SECTOR_RY: c = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
            hsv2rgb_pkg::SECTOR_YG: c = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
            hsv2rgb_pkg::SECTOR_GC: c = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
            hsv2rgb_pkg::SECTOR_CB: c = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
            hsv2rgb_pkg::SECTOR_BM: c = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
            // magenta-red, and hues past 359 fold in here unwrapped
            default:                c = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
        endcase
        return c;
    endfunction

    // Random pixel: mostly legal hues, some above 359; saturation/value extremes weighted up
    function automatic hsv2rgb_pkg::hsv_t random_hsv();
        hsv2rgb_pkg::hsv_t px;
        int                pick;
        pick = $urandom_range(99);
        px.hue_deg = (pick < 80) ? 9'($urandom_range(359)) : 9'($urandom_range(511));
        pick = $urandom_range(99);
        if (pick < 10)
            px.saturation = 8'd0;
        else if (pick < 20)
            px.saturation = 8'd255;
        else
            px.saturation = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 5)
            px.brightness = 8'd0;
        else if (pick < 10)
            px.brightness = 8'd255;
        else
            px.brightness = 8'($urandom_range(255));
        return px;
    endfunction

    // Send one word; idle_pct is the per-cycle chance of holding start low first
    task automatic send_word(input hsv2rgb_pkg::hsv_t px, input int idle_pct);
        pending_px_t entry;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            hsv   <= random_hsv();    // noise on the bus while idle
            @(posedge clk);
        end
        start <= 1'b1;
        hsv   <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        entry.px   = px;
        entry.want = predict_rgb(px);
        pending_px.push_back(entry);
    endtask

    // Result checker: done marks one word per cycle, it cannot be held off
    always @(posedge clk)
    begin
        pending_px_t entry;
        if (rst_n && done)
        begin
            if (pending_px.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result r=%0d g=%0d b=%0d",
                             rgb.red, rgb.green, rgb.blue);
            end
            else
            begin
                entry = pending_px.pop_front();
                if (rgb.red !== entry.want.red || rgb.green !== entry.want.green ||
                    rgb.blue !== entry.want.blue)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: h=%0d s=%0d v=%0d exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 entry.px.hue_deg, entry.px.saturation, entry.px.brightness,
                                 entry.want.red, entry.want.green, entry.want.blue,
                                 rgb.red, rgb.green, rgb.blue);
                end
            end
        end
    end

    // Sector boundaries and hues past 359 at full saturation, then partial saturation and field extremes
    task automatic test_sector_edges();
        int unsigned edge_hue[16] = '{0, 59, 60, 119, 120, 179, 180, 239,
                                      240, 299, 300, 359, 360, 419, 480, 511};
        foreach (edge_hue[i])
            send_word('{hue_deg: 9'(edge_hue[i]), saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue_deg: 9'd30,  saturation: 8'd1,   brightness: 8'd255}, 0);
        send_word('{hue_deg: 9'd200, saturation: 8'd128, brightness: 8'd0},   0);
        send_word('{hue_deg: 9'd90,  saturation: 8'd170, brightness: 8'd1},   0);
    endtask

    // Zero saturation gives grey at every hue, including out-of-range ones
    task automatic test_grey();
        send_word('{hue_deg: 9'd0,   saturation: 8'd0, brightness: 8'd0},   0);
        send_word('{hue_deg: 9'd150, saturation: 8'd0, brightness: 8'd255}, 0);
        send_word('{hue_deg: 9'd359, saturation: 8'd0, brightness: 8'd77},  0);
        send_word('{hue_deg: 9'd511, saturation: 8'd0, brightness: 8'd200}, 0);
    endtask

    // Random stream at a given sender idle rate
    task automatic test_random_stream(input int count, input int idle_pct);
        repeat (count)
            send_word(random_hsv(), idle_pct);
    endtask

    // Stimulus sequence
    initial
    begin
        mismatch_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        hsv   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sector_edges();
        test_grey();
        test_random_stream(170, 0);     // back to back
        test_random_stream(170, 79);    // sparse sender
        test_random_stream(170, 34);    // moderate sender idling
        start <= 1'b0;

        // drain, then give the pipeline time to show any stray word
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_px.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
